### src/mcct_pkg.sv
`default_nettype none

package mcct_pkg;

  // Bank geometry.
  localparam int NUM_CHANNELS = 16;
  localparam int COUNT_BITS   = 32;
  localparam int CH_BITS      = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

  // Fixed field widths of the stream words.
  localparam int CHAN_W  = 4;
  localparam int TOTAL_W = 5;

  // Input item kinds, carried in the slave tuser.
  typedef enum logic [1:0] {
    KIND_TICK  = 2'd0,
    KIND_START = 2'd1,
    KIND_STOP  = 2'd2
  } kind_e;

  // Result event codes, carried in the master tuser.
  typedef enum logic [2:0] {
    EV_EXPIRED   = 3'd0,
    EV_STARTED   = 3'd1,
    EV_START_REJ = 3'd2,
    EV_STOPPED   = 3'd3,
    EV_STOP_REJ  = 3'd4
  } event_e;

  // Scan token handed from cell to cell during a tick.
  typedef struct packed {
    logic               vld;
    logic [CH_BITS-1:0] idx;
  } scan_t;

  // Start or stop command broadcast to the cells.
  typedef struct packed {
    logic                  start;
    logic                  stop;
    logic [COUNT_BITS-1:0] period;
    logic                  periodic;
  } cmd_t;

  // Expiry report of the cell that holds the scan token.
  typedef struct packed {
    logic               hit;
    logic               oneshot;
    logic               last;
    logic [CH_BITS-1:0] idx;
  } hit_t;

endpackage

`default_nettype wire

### src/mcct_cell.sv
`default_nettype none

module mcct_cell import mcct_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  step_en_i,
  input  wire logic  sel_i,
  input  wire cmd_t  cmd_i,
  input  wire scan_t scan_i,
  output scan_t      scan_o,
  input  wire logic  pend_i,
  output logic       pend_o,
  output logic       armed_o,
  output hit_t       hit_o
);

  logic                  armed_q, armed_d;
  logic                  periodic_q, periodic_d;
  logic [COUNT_BITS-1:0] remain_q, remain_d;
  logic [COUNT_BITS-1:0] reload_q, reload_d;
  scan_t                 scan_q;
  logic                  due;

  // The channel expires on the next count when exactly one tick is left.
  assign due = armed_q && (remain_q == COUNT_BITS'(1));

  // Pending expiries at this cell or further down the chain.
  assign pend_o  = due | pend_i;
  assign armed_o = armed_q;

  // The token moves on with the index of the following cell.
  assign scan_o.vld = scan_q.vld;
  assign scan_o.idx = CH_BITS'(scan_q.idx + 1'b1);

  // Report an expiry while the token sits here.
  assign hit_o.hit     = scan_q.vld && due;
  assign hit_o.oneshot = scan_q.vld && due && !periodic_q;
  assign hit_o.last    = !pend_i;
  assign hit_o.idx     = scan_q.idx;

  // Channel state update: commands, or one count when the token is here.
  always_comb begin
    armed_d    = armed_q;
    periodic_d = periodic_q;
    remain_d   = remain_q;
    reload_d   = reload_q;
    if (sel_i && cmd_i.start) begin
      armed_d    = 1'b1;
      periodic_d = cmd_i.periodic;
      remain_d   = cmd_i.period;
      reload_d   = cmd_i.period;
    end else if (sel_i && cmd_i.stop) begin
      armed_d  = 1'b0;
      remain_d = '0;
    end else if (step_en_i && scan_q.vld && armed_q) begin
      remain_d = remain_q - 1'b1;
      if (due) begin
        if (periodic_q) begin
          remain_d = reload_q;
        end else begin
          armed_d = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      armed_q    <= 1'b0;
      periodic_q <= 1'b0;
      remain_q   <= '0;
      reload_q   <= '0;
      scan_q     <= '0;
    end else begin
      armed_q    <= armed_d;
      periodic_q <= periodic_d;
      remain_q   <= remain_d;
      reload_q   <= reload_d;
      if (step_en_i) begin
        scan_q <= scan_i;
      end
    end
  end

endmodule

`default_nettype wire

### src/multi_channel_countdown_timer_core.sv
`default_nettype none

// Bank of countdown timer channels on a pair of streams.
// Slave stream: tuser carries the kind (tick, start, stop); tdata carries the
// channel, the period and the repeat flag. Master stream: tuser carries the
// event code, tdata the channel and the armed-channel count, and tlast marks
// the final word caused by one input word.
// A start or stop word yields exactly one result word in the output register
// on the next cycle. A tick word sends a scan token down the row of channel
// cells, one cell per cycle while the receiver keeps up; each expiring
// channel yields one word, in ascending channel order. A tick with no expiry
// yields nothing.
// A stalled receiver freezes the token and the output register, and no new
// word is taken until the held word leaves. A new start or stop is taken in
// the same cycle that the previous result is read out.
// Reset disarms every channel and clears the armed count and the output.
module multi_channel_countdown_timer_core import mcct_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [39:0] s_axis_tdata,  // channel[3:0], period[35:4], repeat_req[36]
  input  wire logic [1:0]  s_axis_tuser,  // kind[1:0]
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [15:0]      m_axis_tdata,  // which_channel[3:0], running_count[8:4]
  output logic [2:0]       m_axis_tuser,  // event_res[2:0]
  output logic             m_axis_tlast
);

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } state_e;

  state_e               state_q, state_d;
  logic                 out_vld_q;
  logic [CHAN_W-1:0]    out_ch_q;
  logic [TOTAL_W-1:0]   out_cnt_q;
  event_e               out_ev_q;
  logic                 out_last_q;
  logic [TOTAL_W-1:0]   total_q, total_d;

  logic                 step_en, s_fire;
  logic [CHAN_W-1:0]    in_ch;
  logic [COUNT_BITS-1:0] in_period;
  logic                 in_repeat;
  logic                 valid_ch, armed_sel;

  logic                 res_vld, res_last;
  event_e               res_ev;
  logic [CHAN_W-1:0]    res_ch;

  cmd_t                 cmd;
  scan_t                scan_head;
  scan_t                scan_chain [NUM_CHANNELS+1];
  logic                 pend_chain [NUM_CHANNELS+1];
  hit_t                 hits       [NUM_CHANNELS];
  logic [NUM_CHANNELS-1:0] sel, armed;
  hit_t                 hit_any;

  // Unpack the input word.
  assign in_ch     = s_axis_tdata[3:0];
  assign in_period = COUNT_BITS'(s_axis_tdata[35:4]);
  assign in_repeat = s_axis_tdata[36];

  // Everything advances when the output register is free or being emptied.
  assign step_en       = !out_vld_q || m_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE) && step_en;
  assign s_fire        = s_axis_tvalid && s_axis_tready;

  assign valid_ch  = 32'(in_ch) < 32'(NUM_CHANNELS);
  assign armed_sel = |(sel & armed);

  // Row of channel cells; the token enters at the low end, pending
  // expiries ripple up from the high end.
  assign scan_chain[0]            = scan_head;
  assign pend_chain[NUM_CHANNELS] = 1'b0;

  for (genvar i = 0; i < NUM_CHANNELS; i++) begin : g_cell
    assign sel[i] = (32'(in_ch) == 32'(i));

    mcct_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .step_en_i (step_en),
      .sel_i     (sel[i]),
      .cmd_i     (cmd),
      .scan_i    (scan_chain[i]),
      .scan_o    (scan_chain[i+1]),
      .pend_i    (pend_chain[i+1]),
      .pend_o    (pend_chain[i]),
      .armed_o   (armed[i]),
      .hit_o     (hits[i])
    );
  end

  // At most one cell holds the token, so the reports merge by OR.
  always_comb begin
    hit_any = '0;
    for (int i = 0; i < NUM_CHANNELS; i++) begin
      if (hits[i].hit) begin
        hit_any = hit_any | hits[i];
      end
    end
  end

  // Decode input words and scan results into the next output word.
  always_comb begin
    state_d   = state_q;
    total_d   = total_q;
    res_vld   = 1'b0;
    res_last  = 1'b1;
    res_ev    = EV_EXPIRED;
    res_ch    = in_ch;
    cmd       = '0;
    cmd.period   = in_period;
    cmd.periodic = in_repeat;
    scan_head = '0;

    if (s_fire) begin
      unique case (s_axis_tuser)
        KIND_TICK: begin
          scan_head.vld = 1'b1;
          state_d       = ST_SCAN;
        end
        KIND_START: begin
          res_vld = 1'b1;
          if (!valid_ch || in_period == '0 || armed_sel) begin
            res_ev = EV_START_REJ;
          end else begin
            res_ev    = EV_STARTED;
            cmd.start = 1'b1;
            total_d   = total_q + 1'b1;
          end
        end
        KIND_STOP: begin
          res_vld = 1'b1;
          if (!valid_ch || !armed_sel) begin
            res_ev = EV_STOP_REJ;
          end else begin
            res_ev   = EV_STOPPED;
            cmd.stop = 1'b1;
            if (total_q != '0) begin
              total_d = total_q - 1'b1;
            end
          end
        end
        default: begin
        end
      endcase
    end

    if (state_q == ST_SCAN && step_en) begin
      if (hit_any.hit) begin
        res_vld  = 1'b1;
        res_ev   = EV_EXPIRED;
        res_ch   = CHAN_W'(hit_any.idx);
        res_last = hit_any.last;
        if (hit_any.oneshot && total_q != '0) begin
          total_d = total_q - 1'b1;
        end
      end
      if (scan_chain[NUM_CHANNELS].vld) begin
        state_d = ST_IDLE;
      end
    end
  end

  // State, armed count and output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      total_q    <= '0;
      out_vld_q  <= 1'b0;
      out_ch_q   <= '0;
      out_cnt_q  <= '0;
      out_ev_q   <= EV_EXPIRED;
      out_last_q <= 1'b0;
    end else begin
      state_q <= state_d;
      total_q <= total_d;
      if (step_en) begin
        out_vld_q  <= res_vld;
        out_ch_q   <= res_ch;
        out_cnt_q  <= total_d;
        out_ev_q   <= res_ev;
        out_last_q <= res_last;
      end
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {7'b0, out_cnt_q, out_ch_q};
  assign m_axis_tuser  = out_ev_q;
  assign m_axis_tlast  = out_last_q;

endmodule

`default_nettype wire
